@@ rtl/request_response_flow_pairing_core_macros.svh @@
// Assertion macros for the flow pairing core checker.
// Included by the checker file only; no other dependencies.
`ifndef REQUEST_RESPONSE_FLOW_PAIRING_CORE_MACROS_SVH
`define REQUEST_RESPONSE_FLOW_PAIRING_CORE_MACROS_SVH

// Same-cycle implication under reset
`define RRFP_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("rrfp assertion failed");

// Next-cycle implication under reset
`define RRFP_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("rrfp assertion failed");

`endif

@@ rtl/rrfp_pkg.sv @@
// Shared types and codes for the request/response flow pairing core.
// No dependencies.
`default_nettype none
package rrfp_pkg;

	localparam int FLOW_SLOTS_DEF = 64;

	// item kinds
	localparam logic [1:0] KIND_REQ   = 2'd0;
	localparam logic [1:0] KIND_RESP  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OPENED    = 3'd0;
	localparam logic [2:0] ST_NOW_AMBIG = 3'd1;
	localparam logic [2:0] ST_AMBIG     = 3'd2;
	localparam logic [2:0] ST_PAIRED    = 3'd3;
	localparam logic [2:0] ST_NOT_PEND  = 3'd4;
	localparam logic [2:0] ST_NO_FLOW   = 3'd5;
	localparam logic [2:0] ST_CLEARED   = 3'd6;
	localparam logic [2:0] ST_IGNORED   = 3'd7;

	// pending states of a flow
	localparam logic [1:0] PEND_IDLE  = 2'd0;
	localparam logic [1:0] PEND_ONE   = 2'd1;
	localparam logic [1:0] PEND_AMBIG = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] timestamp;
		logic [31:0] request_tag;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        paired;
		logic [31:0] paired_tag;
		logic [5:0]  slot;
		logic        evicted;
	} result_t;

	typedef struct packed {
		logic [31:0] client_addr;
		logic [31:0] server_addr;
		logic [15:0] client_port;
		logic [15:0] server_port;
		logic [1:0]  pend;
		logic [31:0] last_time;
		logic [31:0] tag;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic cmp;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trivial;
		logic empty;
		logic match;
		logic last;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/rrfp_datapath.sv @@
// Flow table memory, scan registers, lookup compare and result register.
// Depends on rrfp_pkg.
`default_nettype none
module rrfp_datapath #(
	parameter int FLOW_SLOTS = rrfp_pkg::FLOW_SLOTS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rrfp_pkg::item_t  item,
	input  wire rrfp_pkg::cmd_t   cmd,
	output rrfp_pkg::sts_t        sts,
	output logic                  result_valid,
	input  wire                   result_stall,
	output rrfp_pkg::result_t     result
);

	localparam int IW = $clog2(FLOW_SLOTS);
	localparam int CW = $clog2(FLOW_SLOTS + 1);

	rrfp_pkg::entry_t mem [FLOW_SLOTS];
	rrfp_pkg::entry_t rdata_q;
	rrfp_pkg::item_t  item_q;
	rrfp_pkg::result_t res_q;
	logic [IW-1:0] idx_q, min_idx_q;
	logic [31:0]   min_time_q;
	logic [CW-1:0] count_q;
	logic          found_q, out_valid_q;

	logic              match, trivial, last;
	logic              wr_en, cnt_inc, cnt_clr;
	logic [IW-1:0]     wr_idx;
	rrfp_pkg::entry_t  wr_data;
	rrfp_pkg::result_t res_d;

	// lookup compare, reversed tuple for responses
	always_comb begin
		if (item_q.kind == rrfp_pkg::KIND_REQ) begin
			match = rdata_q.client_port == item_q.source_port &&
				rdata_q.server_port == item_q.dest_port &&
				rdata_q.client_addr == item_q.source_addr &&
				rdata_q.server_addr == item_q.dest_addr;
		end else begin
			match = rdata_q.client_port == item_q.dest_port &&
				rdata_q.server_port == item_q.source_port &&
				rdata_q.client_addr == item_q.dest_addr &&
				rdata_q.server_addr == item_q.source_addr;
		end
		trivial = item_q.kind == rrfp_pkg::KIND_CLEAR ||
			(item_q.kind != rrfp_pkg::KIND_REQ && item_q.kind != rrfp_pkg::KIND_RESP) ||
			(item_q.kind == rrfp_pkg::KIND_REQ &&
			(item_q.source_addr == 32'd0 || item_q.dest_addr == 32'd0));
		last = (CW'(idx_q) + CW'(1)) == count_q;
	end

	assign sts.trivial  = trivial;
	assign sts.empty    = count_q == '0;
	assign sts.match    = match;
	assign sts.last     = last;
	assign sts.out_busy = out_valid_q && result_stall;

	// final update and result for the item
	always_comb begin
		res_d   = '0;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_data = rdata_q;
		cnt_inc = 1'b0;
		cnt_clr = 1'b0;
		case (item_q.kind)
			rrfp_pkg::KIND_REQ: begin
				if (trivial) begin
					res_d.status = rrfp_pkg::ST_IGNORED;
				end else begin
					if (!found_q) begin
						wr_data.client_addr = item_q.source_addr;
						wr_data.server_addr = item_q.dest_addr;
						wr_data.client_port = item_q.source_port;
						wr_data.server_port = item_q.dest_port;
						wr_data.pend        = rrfp_pkg::PEND_IDLE;
						wr_data.tag         = 32'd0;
						if (count_q < CW'(FLOW_SLOTS)) begin
							wr_idx  = IW'(count_q);
							cnt_inc = 1'b1;
						end else begin
							wr_idx        = min_idx_q;
							res_d.evicted = 1'b1;
						end
					end
					if (wr_data.pend == rrfp_pkg::PEND_ONE) begin
						wr_data.pend = rrfp_pkg::PEND_AMBIG;
						res_d.status = rrfp_pkg::ST_NOW_AMBIG;
					end else if (wr_data.pend == rrfp_pkg::PEND_AMBIG) begin
						res_d.status = rrfp_pkg::ST_AMBIG;
					end else begin
						wr_data.pend = rrfp_pkg::PEND_ONE;
						wr_data.tag  = item_q.request_tag;
						res_d.status = rrfp_pkg::ST_OPENED;
					end
					wr_data.last_time = item_q.timestamp;
					wr_en      = 1'b1;
					res_d.slot = 6'(wr_idx);
				end
			end
			rrfp_pkg::KIND_RESP: begin
				if (found_q) begin
					wr_en        = 1'b1;
					wr_data.pend = rrfp_pkg::PEND_IDLE;
					res_d.slot   = 6'(idx_q);
					if (rdata_q.pend == rrfp_pkg::PEND_ONE) begin
						res_d.status     = rrfp_pkg::ST_PAIRED;
						res_d.paired     = 1'b1;
						res_d.paired_tag = rdata_q.tag;
					end else begin
						res_d.status = rrfp_pkg::ST_NOT_PEND;
					end
				end else begin
					res_d.status = rrfp_pkg::ST_NO_FLOW;
				end
			end
			rrfp_pkg::KIND_CLEAR: begin
				res_d.status = rrfp_pkg::ST_CLEARED;
				cnt_clr      = 1'b1;
			end
			default: begin
				res_d.status = rrfp_pkg::ST_IGNORED;
			end
		endcase
	end

	// flow table memory
	always_ff @(posedge clk) begin
		if (cmd.fin && wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	// item and scan payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.cmp && !match && (idx_q == '0 || rdata_q.last_time < min_time_q)) begin
			min_idx_q  <= idx_q;
			min_time_q <= rdata_q.last_time;
		end
		if (cmd.fin) begin
			res_q <= res_d;
		end
	end

	// scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.cmp) begin
				if (match) begin
					found_q <= 1'b1;
				end else if (!last) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (cmd.fin) begin
				if (cnt_clr) begin
					count_q <= '0;
				end else if (cnt_inc) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

@@ rtl/rrfp_ctrl.sv @@
// Controller state machine sequencing accept, table scan and final update.
// Depends on rrfp_pkg.
`default_nettype none
module rrfp_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  wire rrfp_pkg::sts_t sts,
	output rrfp_pkg::cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK  = 5'b00010,
		S_RD   = 5'b00100,
		S_CMP  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// commands
	always_comb begin
		item_stall = state_q != S_IDLE;
		cmd.load   = state_q == S_IDLE && item_valid;
		cmd.rd     = state_q == S_RD;
		cmd.cmp    = state_q == S_CMP;
		cmd.fin    = state_q == S_FIN && !sts.out_busy;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_CHK;
			end
			S_CHK: begin
				state_d = (sts.trivial || sts.empty) ? S_FIN : S_RD;
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = (sts.match || sts.last) ? S_FIN : S_RD;
			end
			S_FIN: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/request_response_flow_pairing_core.sv @@
// After the item is accepted the controller runs the check, then a read and a compare
// per slot read by the lookup (none for clear, ignored items and an empty table; all
// flows in use when the lookup misses), then the final update, which a held result can
// block. One item at a time: the next item is accepted only after the final update.
// Reset: the flow count clears at once; table contents stay undefined, no sweep.
`default_nettype none
module request_response_flow_pairing_core #(
	parameter int FLOW_SLOTS = rrfp_pkg::FLOW_SLOTS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_stall,
	input  wire rrfp_pkg::item_t    item,
	output logic                    result_valid,
	input  wire                     result_stall,
	output rrfp_pkg::result_t       result
);

	rrfp_pkg::cmd_t cmd;
	rrfp_pkg::sts_t sts;

	rrfp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	rrfp_datapath #(
		.FLOW_SLOTS (FLOW_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

@@ rtl/rrfp_checker.sv @@
// Port-level checker for the flow pairing core, bound to the top level.
// Depends on rrfp_pkg and the macros header.
`default_nettype none
`include "request_response_flow_pairing_core_macros.svh"
module rrfp_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    item_valid,
	input wire                    item_stall,
	input wire                    result_valid,
	input wire                    result_stall,
	input wire rrfp_pkg::result_t result
);

	// a held result keeps its payload
	`RRFP_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && result_stall, $stable(result))
	// one item in flight: no accept right after an accept
	`RRFP_ASSERT_NEXT(a_one_item, clk, arst_n, item_valid && !item_stall, item_stall)
	// only a pairing carries a tag
	`RRFP_ASSERT_NOW(a_paired, clk, arst_n, result_valid && result.paired,
		result.status == rrfp_pkg::ST_PAIRED)
	// eviction always opens a fresh flow
	`RRFP_ASSERT_NOW(a_evict, clk, arst_n, result_valid && result.evicted,
		result.status == rrfp_pkg::ST_OPENED)
	// a clear touches no slot
	`RRFP_ASSERT_NOW(a_clear, clk, arst_n, result_valid && result.status == rrfp_pkg::ST_CLEARED,
		result.slot == 6'd0 && !result.paired)

endmodule

bind request_response_flow_pairing_core rrfp_checker u_rrfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire

@@ tb/sv/request_response_flow_pairing_core_tb.sv @@
// Testbench for the request/response flow pairing core: directed table, evictions, random traffic.
// Depends on rrfp_pkg and request_response_flow_pairing_core; a built-in flow table predicts results.
`default_nettype none
module request_response_flow_pairing_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrfp_pkg::*;

	localparam int SLOTS = FLOW_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 900000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	request_response_flow_pairing_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #4 clk = ~clk;

	// predictor copy of the flow table
	logic [31:0] tbl_caddr [SLOTS];
	logic [31:0] tbl_saddr [SLOTS];
	logic [15:0] tbl_cport [SLOTS];
	logic [15:0] tbl_sport [SLOTS];
	logic [1:0]  tbl_pend [SLOTS];
	logic [31:0] tbl_time [SLOTS];
	logic [31:0] tbl_tag [SLOTS];
	int          tbl_used;

	result_t pending_results[$];
	int      fail_count = 0;
	int      cycle_count = 0;
	bit      quiet_tail = 0;

	// recently used tuples, to build matching requests and responses
	item_t recent_flows[$];

	function automatic result_t predict_flow_result(item_t it);
		result_t r;
		int idx;
		bit found;
		r = '0;
		case (it.kind)
			KIND_REQ: begin
				if (it.source_addr == 0 || it.dest_addr == 0) begin
					r.status = ST_IGNORED;
					return r;
				end
				found = 0;
				idx = 0;
				for (int i = 0; i < tbl_used; i++)
					if (!found && tbl_cport[i] == it.source_port && tbl_sport[i] == it.dest_port
							&& tbl_caddr[i] == it.source_addr && tbl_saddr[i] == it.dest_addr) begin
						idx = i;
						found = 1;
					end
				if (!found) begin
					if (tbl_used < SLOTS) begin
						idx = tbl_used;
						tbl_used++;
					end else begin
						// evict oldest, lowest index on ties
						idx = 0;
						for (int i = 1; i < SLOTS; i++)
							if (tbl_time[i] < tbl_time[idx]) idx = i;
						r.evicted = 1'b1;
					end
					tbl_caddr[idx] = it.source_addr;
					tbl_saddr[idx] = it.dest_addr;
					tbl_cport[idx] = it.source_port;
					tbl_sport[idx] = it.dest_port;
					tbl_pend[idx] = PEND_IDLE;
					tbl_tag[idx] = '0;
				end
				if (tbl_pend[idx] == PEND_ONE) begin
					tbl_pend[idx] = PEND_AMBIG;
					r.status = ST_NOW_AMBIG;
				end else if (tbl_pend[idx] == PEND_AMBIG) begin
					r.status = ST_AMBIG;
				end else begin
					tbl_pend[idx] = PEND_ONE;
					tbl_tag[idx] = it.request_tag;
					r.status = ST_OPENED;
				end
				tbl_time[idx] = it.timestamp;
				r.slot = idx[5:0];
			end
			KIND_RESP: begin
				r.status = ST_NO_FLOW;
				found = 0;
				for (int i = 0; i < tbl_used; i++)
					if (!found && tbl_cport[i] == it.dest_port && tbl_sport[i] == it.source_port
							&& tbl_caddr[i] == it.dest_addr && tbl_saddr[i] == it.source_addr) begin
						found = 1;
						if (tbl_pend[i] == PEND_ONE) begin
							r.status = ST_PAIRED;
							r.paired = 1'b1;
							r.paired_tag = tbl_tag[i];
						end else begin
							r.status = ST_NOT_PEND;
						end
						tbl_pend[i] = PEND_IDLE;
						r.slot = i[5:0];
					end
			end
			KIND_CLEAR: begin
				tbl_used = 0;
				r.status = ST_CLEARED;
			end
			default: r.status = ST_IGNORED;
		endcase
		return r;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result status=%0d", result.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.paired !== want.paired) begin
					$error("paired: expected %0d, got %0d", want.paired, result.paired);
					fail_count++;
				end
				if (result.paired_tag !== want.paired_tag) begin
					$error("paired_tag: expected %h, got %h", want.paired_tag, result.paired_tag);
					fail_count++;
				end
				if (result.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, result.slot);
					fail_count++;
				end
				if (result.evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, result.evicted);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls in random bursts
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 11);
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// send one item, with optional sender gap before it
	task automatic send_item(item_t it, bit has_fixed, result_t fixed);
		result_t want;
		int gap;
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		want = predict_flow_result(it);
		if (has_fixed && want != fixed) begin
			$error("table row: expected %p, predictor %p", fixed, want);
			fail_count++;
		end
		pending_results.push_back(want);
		if (it.kind == KIND_REQ && it.source_addr != 0 && it.dest_addr != 0) begin
			recent_flows.push_back(it);
			if (recent_flows.size() > 80) void'(recent_flows.pop_front());
		end
		@(negedge clk);
	endtask

	function automatic item_t make_item(logic [1:0] k, logic [31:0] sa, logic [31:0] da,
			logic [15:0] sp, logic [15:0] dp, logic [31:0] ts, logic [31:0] tg);
		item_t it;
		it.kind = k;
		it.source_addr = sa;
		it.dest_addr = da;
		it.source_port = sp;
		it.dest_port = dp;
		it.timestamp = ts;
		it.request_tag = tg;
		return it;
	endfunction

	function automatic result_t make_result(logic [2:0] st, logic pr, logic [31:0] tg,
			logic [5:0] sl, logic ev);
		result_t r;
		r.status = st;
		r.paired = pr;
		r.paired_tag = tg;
		r.slot = sl;
		r.evicted = ev;
		return r;
	endfunction

	// random item: mostly requests/responses over a small pool of flows
	function automatic item_t random_flow_item(int tsbase);
		item_t it;
		item_t f;
		int pick;
		it = make_item(KIND_REQ, $urandom, $urandom, $urandom, $urandom,
			tsbase + $urandom_range(0, 40), $urandom);
		if ($urandom_range(0, 1)) begin
			it.source_addr = 32'h0A00_0000 | $urandom_range(1, 6);
			it.dest_addr = 32'hC0A8_0000 | $urandom_range(1, 3);
			it.source_port = 16'(1000 + $urandom_range(0, 9));
			it.dest_port = 16'd80;
		end
		pick = $urandom_range(0, 99);
		if (pick < 40 && recent_flows.size() > 0) begin
			f = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
			it.kind = KIND_RESP;
			it.source_addr = f.dest_addr;
			it.dest_addr = f.source_addr;
			it.source_port = f.dest_port;
			it.dest_port = f.source_port;
		end else if (pick < 55 && recent_flows.size() > 0) begin
			f = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
			it.source_addr = f.source_addr;
			it.dest_addr = f.dest_addr;
			it.source_port = f.source_port;
			it.dest_port = f.dest_port;
		end else if (pick < 58) begin
			it.source_addr = 0;
		end else if (pick < 61) begin
			it.dest_addr = 0;
		end else if (pick < 63) begin
			it.kind = 2'd3;
		end else if (pick < 64) begin
			it.kind = KIND_CLEAR;
		end else if (pick < 70) begin
			it.kind = KIND_RESP;
		end
		return it;
	endfunction

	typedef struct {
		item_t   it;
		bit      has_fixed;
		result_t fixed;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		int tsbase;
		tbl_used = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_caddr[i] = '0; tbl_saddr[i] = '0; tbl_cport[i] = '0; tbl_sport[i] = '0;
			tbl_pend[i] = PEND_IDLE; tbl_time[i] = '0; tbl_tag[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		rows.push_back('{make_item(KIND_RESP, 32'h1, 32'h2, 16'h3, 16'h4, 0, 0), 1,
			make_result(ST_NO_FLOW, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, make_result(ST_OPENED, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			32'h5, 32'h1234), 1, make_result(ST_NOW_AMBIG, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			32'h6, 32'h1), 1, make_result(ST_AMBIG, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_RESP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			0, 0), 1, make_result(ST_NOT_PEND, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'h1, 32'h1, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF),
			1, make_result(ST_OPENED, 0, 0, 1, 0)});
		rows.push_back('{make_item(KIND_RESP, 32'h1, 32'h1, 16'h0, 16'h0, 0, 0), 1,
			make_result(ST_PAIRED, 1, 32'hFFFF_FFFF, 1, 0)});
		rows.push_back('{make_item(KIND_RESP, 32'h1, 32'h1, 16'h0, 16'h0, 0, 0), 1,
			make_result(ST_NOT_PEND, 0, 0, 1, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'h0, 32'h7, 16'h1, 16'h2, 3, 3), 1,
			make_result(ST_IGNORED, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'h7, 32'h0, 16'h1, 16'h2, 3, 3), 1,
			make_result(ST_IGNORED, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_RESP, 32'h0, 32'h0, 16'h0, 16'h0, 0, 0), 1,
			make_result(ST_NO_FLOW, 0, 0, 0, 0)});
		rows.push_back('{make_item(2'd3, 32'hFFFF_FFFF, 32'h1, 16'h1, 16'h1, 1, 1), 1,
			make_result(ST_IGNORED, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_REQ, 32'hA, 32'hB, 16'h5, 16'h6, 9, 32'hAA55), 0, '0});
		rows.push_back('{make_item(KIND_RESP, 32'hB, 32'hA, 16'h6, 16'h5, 0, 0), 0, '0});
		rows.push_back('{make_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 1,
			make_result(ST_CLEARED, 0, 0, 0, 0)});
		rows.push_back('{make_item(KIND_RESP, 32'hB, 32'hA, 16'h6, 16'h5, 0, 0), 1,
			make_result(ST_NO_FLOW, 0, 0, 0, 0)});
		foreach (rows[i]) send_item(rows[i].it, rows[i].has_fixed, rows[i].fixed);

		// fill the table and force evictions, ties included
		for (int i = 0; i < SLOTS + 6; i++)
			send_item(make_item(KIND_REQ, 32'h5000 + i, 32'h6000, 16'(i), 16'd443,
				(i < SLOTS) ? 32'(i % 4) : 32'h8000_0000, 32'(i)), 0, '0);

		// drain once with the sender held back
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);

		// random traffic; occasional random clears keep lookups short
		tsbase = 100;
		for (int n = 0; n < 1200; n++) begin
			if (n == 1050) quiet_tail = 1;
			if (n % 7 == 0) tsbase += $urandom_range(0, 30);
			send_item(random_flow_item(tsbase), 0, '0);
		end
		item_valid <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/rrfp_pkg.sv
rtl/rrfp_datapath.sv
rtl/rrfp_ctrl.sv
rtl/request_response_flow_pairing_core.sv
rtl/rrfp_checker.sv
tb/sv/request_response_flow_pairing_core_tb.sv
